>>> src/arxp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arxp_pkg
// Types, constants and word shuffles shared by the 512-bit ARX permutation.
// ----------------------------------------------------------------------------
package arxp_pkg;

  localparam int unsigned MaxRounds = 32;
  localparam int unsigned RoundW    = 6;

  localparam logic [63:0] RcStepLo = 64'h0504070601000302;
  localparam logic [63:0] RcStepHi = 64'h0D0C0F0E09080B0A;

  typedef logic [1:0][63:0] lane_pair_t;
  typedef logic [3:0][31:0] words_t;
  typedef logic [3:0][1:0]  sel_t;

  typedef struct packed {
    lane_pair_t d;
    lane_pair_t c;
    lane_pair_t b;
    lane_pair_t a;
  } state_t;

  localparam sel_t SelB = {2'd1, 2'd2, 2'd3, 2'd0};
  localparam sel_t SelC = {2'd2, 2'd3, 2'd0, 2'd1};
  localparam sel_t SelD = {2'd3, 2'd0, 2'd1, 2'd2};

  function automatic logic [63:0] rc_lane(input int unsigned idx, input logic [63:0] step);
    return 64'd1 + 64'(idx) * step;
  endfunction

  function automatic lane_pair_t swap_halves(input lane_pair_t x);
    words_t w;
    words_t r;
    w = words_t'(x);
    for (int i = 0; i < 4; i++) begin
      r[i] = {w[i][15:0], w[i][31:16]};
    end
    return lane_pair_t'(r);
  endfunction

  function automatic lane_pair_t reorder(input lane_pair_t x, input sel_t sel);
    words_t w;
    words_t r;
    w = words_t'(x);
    for (int i = 0; i < 4; i++) begin
      r[i] = w[sel[i]];
    end
    return lane_pair_t'(r);
  endfunction

endpackage
`default_nettype wire

>>> src/arxp_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arxp_round
// One permutation round in two register stages: constant add and first mix
// pass, then second mix pass and word shuffles. Disabled rounds pass through.
// ----------------------------------------------------------------------------
module arxp_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                en_i,
  input  arxp_pkg::lane_pair_t rc_i,
  input  arxp_pkg::state_t    state_i,
  output logic                valid_o,
  output arxp_pkg::state_t    state_o
);
  import arxp_pkg::*;

  state_t mid_d, mid_q;
  state_t out_d, out_q;
  logic   mid_valid_q, out_valid_q;

  always_comb begin
    mid_d = state_i;
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        mid_d.a[k] = state_i.a[k] + rc_i[k] + state_i.b[k];
        mid_d.c[k] = state_i.c[k] + state_i.d[k];
        mid_d.b[k] = state_i.b[k] ^ mid_d.c[k];
        mid_d.d[k] = state_i.d[k] ^ mid_d.a[k];
      end
    end
  end

  always_comb begin
    out_d = mid_q;
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        out_d.a[k] = mid_q.a[k] + mid_q.b[k];
        out_d.c[k] = mid_q.c[k] + mid_q.d[k];
        out_d.b[k] = mid_q.b[k] ^ out_d.c[k];
        out_d.d[k] = mid_q.d[k] ^ out_d.a[k];
      end
      out_d.a = swap_halves(out_d.a);
      out_d.b = reorder(out_d.b, SelB);
      out_d.c = reorder(out_d.c, SelC);
      out_d.d = reorder(out_d.d, SelD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    out_q <= out_d;
  end

  assign valid_o = out_valid_q;
  assign state_o = out_q;

  a_mid_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_q |-> $past(valid_i))
    else $error("mid stage valid without request");

  a_out_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(mid_valid_q))
    else $error("out stage valid without mid stage");

  a_bypass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(en_i) && !$past(en_i, 2)) |-> (state_o == $past(state_i, 2)))
    else $error("disabled round altered the state");

endmodule
`default_nettype wire

>>> src/arx_permutation_512.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arx_permutation_512
// 512-bit ARX permutation, 32 unrolled rounds of two stages each.
// ----------------------------------------------------------------------------
// A request is registered at the input and then passes both register stages of every round to the result strobe.
// Throughput: one request per cycle; busy_o is never raised.
// Each round is two register stages (one 64-bit add chain per stage).
// Rounds past round_count pass the state through, so latency is fixed.
// Reset clears all valid bits and sets round_count to 32.
module arx_permutation_512 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic [63:0] in_a_low_i,
  input  logic [63:0] in_a_high_i,
  input  logic [63:0] in_b_low_i,
  input  logic [63:0] in_b_high_i,
  input  logic [63:0] in_c_low_i,
  input  logic [63:0] in_c_high_i,
  input  logic [63:0] in_d_low_i,
  input  logic [63:0] in_d_high_i,
  output logic        out_valid_o,
  output logic [63:0] out_a_low_o,
  output logic [63:0] out_a_high_o,
  output logic [63:0] out_b_low_o,
  output logic [63:0] out_b_high_o,
  output logic [63:0] out_c_low_o,
  output logic [63:0] out_c_high_o,
  output logic [63:0] out_d_low_o,
  output logic [63:0] out_d_high_o
);
  import arxp_pkg::*;

  logic [RoundW-1:0] rounds_q, rounds_d;
  logic              in_valid_q;
  state_t            in_q;
  state_t            st    [MaxRounds+1];
  logic              vld   [MaxRounds+1];
  logic              accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_comb begin
    rounds_d = rounds_q;
    if (cfg_we_i) begin
      rounds_d = (cfg_wdata_i > RoundW'(MaxRounds)) ? RoundW'(MaxRounds) : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q   <= RoundW'(MaxRounds);
      in_valid_q <= 1'b0;
    end else begin
      rounds_q   <= rounds_d;
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q.a <= {in_a_high_i, in_a_low_i};
    in_q.b <= {in_b_high_i, in_b_low_i};
    in_q.c <= {in_c_high_i, in_c_low_i};
    in_q.d <= {in_d_high_i, in_d_low_i};
  end

  assign st[0]  = in_q;
  assign vld[0] = in_valid_q;

  for (genvar r = 0; r < MaxRounds; r++) begin : g_round
    localparam lane_pair_t Rc = {rc_lane(r, RcStepHi), rc_lane(r, RcStepLo)};
    logic en;
    assign en = (RoundW'(r) < rounds_q);

    arxp_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[r]),
      .en_i    (en),
      .rc_i    (Rc),
      .state_i (st[r]),
      .valid_o (vld[r+1]),
      .state_o (st[r+1])
    );
  end

  assign out_valid_o  = vld[MaxRounds];
  assign out_a_low_o  = st[MaxRounds].a[0];
  assign out_a_high_o = st[MaxRounds].a[1];
  assign out_b_low_o  = st[MaxRounds].b[0];
  assign out_b_high_o = st[MaxRounds].b[1];
  assign out_c_low_o  = st[MaxRounds].c[0];
  assign out_c_high_o = st[MaxRounds].c[1];
  assign out_d_low_o  = st[MaxRounds].d[0];
  assign out_d_high_o = st[MaxRounds].d[1];

  a_rounds_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rounds_q <= RoundW'(MaxRounds))
    else $error("round count above maximum");

  a_rounds_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (rounds_q == (($past(cfg_wdata_i) > RoundW'(MaxRounds)) ?
                               RoundW'(MaxRounds) : $past(cfg_wdata_i))))
    else $error("round count write not taken");

  a_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> in_valid_q)
    else $error("request dropped at input");

endmodule
`default_nettype wire

>>> sim/tb_arx_permutation_512.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arx_permutation_512
// Drives 512-bit states into the ARX permutation under several round counts,
// random gaps and bursts, and checks every lane of each result against an
// in-order model of the rounds.
// ----------------------------------------------------------------------------
module tb_arx_permutation_512;

  import arxp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 80;

  typedef enum logic [1:0] {REQ_STATE, REQ_ROUNDS, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e   kind;
    state_t      st;
    logic [5:0]  rounds;
    int unsigned gap;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic [63:0] in_a_low_i = '0;
  logic [63:0] in_a_high_i = '0;
  logic [63:0] in_b_low_i = '0;
  logic [63:0] in_b_high_i = '0;
  logic [63:0] in_c_low_i = '0;
  logic [63:0] in_c_high_i = '0;
  logic [63:0] in_d_low_i = '0;
  logic [63:0] in_d_high_i = '0;
  logic        out_valid_o;
  logic [63:0] out_a_low_o;
  logic [63:0] out_a_high_o;
  logic [63:0] out_b_low_o;
  logic [63:0] out_b_high_o;
  logic [63:0] out_c_low_o;
  logic [63:0] out_c_high_o;
  logic [63:0] out_d_low_o;
  logic [63:0] out_d_high_o;

  request_t    request_q[$];
  state_t      expected_states_q[$];
  state_t      drive_state = '0;
  logic [5:0]  rounds_cfg = 6'd32;
  int unsigned gap_cnt = 0;
  int unsigned states_queued = 0;
  int unsigned states_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  string       lane_names [8] = '{"a_low", "a_high", "b_low", "b_high",
                                  "c_low", "c_high", "d_low", "d_high"};

  arx_permutation_512 DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_a_low_i   (in_a_low_i),
    .in_a_high_i  (in_a_high_i),
    .in_b_low_i   (in_b_low_i),
    .in_b_high_i  (in_b_high_i),
    .in_c_low_i   (in_c_low_i),
    .in_c_high_i  (in_c_high_i),
    .in_d_low_i   (in_d_low_i),
    .in_d_high_i  (in_d_high_i),
    .out_valid_o  (out_valid_o),
    .out_a_low_o  (out_a_low_o),
    .out_a_high_o (out_a_high_o),
    .out_b_low_o  (out_b_low_o),
    .out_b_high_o (out_b_high_o),
    .out_c_low_o  (out_c_low_o),
    .out_c_high_o (out_c_high_o),
    .out_d_low_o  (out_d_low_o),
    .out_d_high_o (out_d_high_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic state_t permute_state(state_t s, logic [5:0] rounds);
    logic [63:0] t [2];
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned n;
    n = (rounds > MaxRounds) ? MaxRounds : rounds;
    t[0] = 64'd1;
    t[1] = 64'd1;
    for (int unsigned r = 0; r < n; r++) begin
      for (int k = 0; k < 2; k++) begin
        s.a[k] = s.a[k] + t[k];
      end
      t[0] = t[0] + RcStepLo;
      t[1] = t[1] + RcStepHi;
      repeat (2) begin
        for (int k = 0; k < 2; k++) begin
          s.a[k] = s.a[k] + s.b[k];
          s.c[k] = s.c[k] + s.d[k];
          s.b[k] = s.b[k] ^ s.c[k];
          s.d[k] = s.d[k] ^ s.a[k];
        end
      end
      for (int k = 0; k < 2; k++) begin
        s.a[k] = {s.a[k][47:32], s.a[k][63:48], s.a[k][15:0], s.a[k][31:16]};
        s.c[k] = {s.c[k][31:0], s.c[k][63:32]};
      end
      lo = {s.b[1][63:32], s.b[0][31:0]};
      hi = {s.b[0][63:32], s.b[1][31:0]};
      s.b[0] = lo;
      s.b[1] = hi;
      lo = {s.d[0][63:32], s.d[1][31:0]};
      hi = {s.d[1][63:32], s.d[0][31:0]};
      s.d[0] = lo;
      s.d[1] = hi;
    end
    return s;
  endfunction

  function automatic logic [63:0] rand_lane();
    int unsigned bit_pos;
    bit_pos = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << bit_pos;
      3: return ~(64'd1 << bit_pos);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_state(state_t s, int unsigned gap);
    request_t req;
    req.kind = REQ_STATE;
    req.st = s;
    req.rounds = '0;
    req.gap = gap;
    request_q.push_back(req);
    states_queued++;
  endtask

  task automatic add_marker(req_kind_e kind, logic [5:0] rounds);
    request_t req;
    req.kind = kind;
    req.st = '0;
    req.rounds = rounds;
    req.gap = 0;
    request_q.push_back(req);
  endtask

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Driver: hold a request until accepted, write rounds only when drained.
  always @(posedge clk_i) begin : drive_proc
    logic     nxt_start;
    logic     nxt_we;
    request_t head;
    if (rst_ni) begin
      nxt_start = start_i && busy_o;
      nxt_we = 1'b0;
      if (start_i && !busy_o) begin
        expected_states_q.push_back(permute_state(drive_state, rounds_cfg));
      end
      if (cfg_we_i) begin
        rounds_cfg = cfg_wdata_i;
      end
      if (!nxt_start && request_q.size() > 0) begin
        head = request_q[0];
        case (head.kind)
          REQ_STATE: begin
            if (gap_cnt < head.gap) begin
              gap_cnt++;
            end else begin
              gap_cnt = 0;
              nxt_start = 1'b1;
              drive_state = head.st;
              void'(request_q.pop_front());
            end
          end
          REQ_ROUNDS: begin
            if (expected_states_q.size() == 0 && !cfg_we_i) begin
              nxt_we = 1'b1;
              cfg_wdata_i <= head.rounds;
              void'(request_q.pop_front());
            end
          end
          default: begin
            if (expected_states_q.size() == 0) begin
              void'(request_q.pop_front());
            end
          end
        endcase
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
      in_a_low_i <= drive_state.a[0];
      in_a_high_i <= drive_state.a[1];
      in_b_low_i <= drive_state.b[0];
      in_b_high_i <= drive_state.b[1];
      in_c_low_i <= drive_state.c[0];
      in_c_high_i <= drive_state.c[1];
      in_d_low_i <= drive_state.d[0];
      in_d_high_i <= drive_state.d[1];
    end
  end

  always @(posedge clk_i) begin : check_proc
    state_t       got;
    state_t       want;
    logic [511:0] got_v;
    logic [511:0] want_v;
    if (rst_ni && out_valid_o) begin
      got.a[0] = out_a_low_o;
      got.a[1] = out_a_high_o;
      got.b[0] = out_b_low_o;
      got.b[1] = out_b_high_o;
      got.c[0] = out_c_low_o;
      got.c[1] = out_c_high_o;
      got.d[0] = out_d_low_o;
      got.d[1] = out_d_high_o;
      got_v = got;
      if (expected_states_q.size() == 0) begin
        note_mismatch("unexpected result a_low", 'x, got_v[63:0]);
      end else begin
        want = expected_states_q.pop_front();
        want_v = want;
        states_checked++;
        for (int i = 0; i < 8; i++) begin
          if (got_v[64*i +: 64] !== want_v[64*i +: 64]) begin
            note_mismatch(lane_names[i], want_v[64*i +: 64], got_v[64*i +: 64]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [511:0] v;
    logic [5:0]   phase_rounds [12];
    logic         burst;

    // Directed states under the reset round count.
    add_state('0, 0);
    add_state('1, 0);
    add_state({8{64'hAAAA_AAAA_AAAA_AAAA}}, 1);
    add_state({8{64'h5555_5555_5555_5555}}, 0);
    add_state({8{64'h0000_0000_0000_0001}}, 3);
    add_state({8{64'h8000_0000_0000_0000}}, 0);
    for (int i = 0; i < 8; i++) begin
      v = '0;
      v[64*i +: 64] = '1;
      add_state(state_t'(v), i % 3);
    end
    // Zero rounds pass through; counts above the maximum saturate.
    add_marker(REQ_ROUNDS, 6'd0);
    add_state('1, 0);
    add_state({8{64'h0123_4567_89AB_CDEF}}, 2);
    add_marker(REQ_ROUNDS, 6'd63);
    add_state('0, 0);
    add_state('1, 1);

    phase_rounds = '{6'd1, 6'd2, 6'd32, 6'd0, 6'd63, 6'd33, 6'd31, 6'd16,
                     6'd3, 6'd32, 6'd0, 6'd0};
    phase_rounds[10] = 6'($urandom_range(0, 63));
    phase_rounds[11] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 12; p++) begin
      add_marker(REQ_ROUNDS, phase_rounds[p]);
      burst = (p % 3 == 0);
      for (int n = 0; n < 34; n++) begin
        for (int i = 0; i < 8; i++) begin
          v[64*i +: 64] = rand_lane();
        end
        add_state(state_t'(v), burst ? 0 : $urandom_range(0, 7));
        if (p == 5 && n == 17) begin
          add_marker(REQ_DRAIN, '0);
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (states_checked < states_queued) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_states_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
